// ===== hdl/sorted_key_table_with_binary_search_assert.svh =====
// ---------------------------------------------------------------------------
// sorted key table assertion macros
// concurrent checks sampled on clk, masked while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_WITH_BINARY_SEARCH_ASSERT_SVH
`define SORTED_KEY_TABLE_WITH_BINARY_SEARCH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SKT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/skt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_pkg
// shared constants, codes and control structs of the sorted key table
// ---------------------------------------------------------------------------
package skt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int POS_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SGN_W       = CNT_W + 1;

  localparam int OP_W   = 2;
  localparam int NUM_W  = 8;
  localparam int KEY_W  = 24;
  localparam int WGT_W  = 32;
  localparam int STAT_W = 2;
  localparam int NC_W   = (NUM_W > CNT_W) ? NUM_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 2'd0,
    OP_INSERT     = 2'd1,
    OP_KEY_LOOKUP = 2'd2,
    OP_NUM_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [KEY_W-1:0] key;
    logic [WGT_W-1:0] weight;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UB_PROBE,
    S_UB_CMP,
    S_SHIFT,
    S_MAP,
    S_KS_PROBE,
    S_KS_CMP,
    S_NL_MAP,
    S_NL_ENT,
    S_RESP_OK,
    S_RESP_MISS,
    S_RESP_FULL,
    S_RESP_ENT
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    clear;
    logic    ub_init;
    logic    ub_probe;
    logic    ub_step;
    logic    sh_init;
    logic    sh_step;
    logic    map_init;
    logic    map_step;
    logic    ks_init;
    logic    ks_probe;
    logic    ks_step;
    logic    nl_map_rd;
    logic    nl_ent_rd;
    logic    res_load;
    status_t res_status;
    logic    res_entry;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic count_full;
    logic num_bad;
    logic ub_done;
    logic sh_fin;
    logic mp_fin;
    logic ks_eq;
    logic ks_last;
    logic ks_cont;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/skt_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_ctrl
// operation sequencer: search, shift, map upkeep and result hand-off
// ---------------------------------------------------------------------------
module skt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  skt_pkg::sts_t sts,
  output skt_pkg::cmd_t cmd
);
  import skt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RESP_OK;
          end
          OP_INSERT: begin
            if (sts.count_full) begin
              state_nxt = S_RESP_FULL;
            end else begin
              cmd.ub_init = 1'b1;
              state_nxt   = S_UB_PROBE;
            end
          end
          OP_KEY_LOOKUP: begin
            if (sts.count_zero) begin
              state_nxt = S_RESP_MISS;
            end else begin
              cmd.ks_init = 1'b1;
              state_nxt   = S_KS_PROBE;
            end
          end
          default: begin
            if (sts.num_bad) begin
              state_nxt = S_RESP_MISS;
            end else begin
              state_nxt = S_NL_MAP;
            end
          end
        endcase
      end
      // upper-bound search for the insert position
      S_UB_PROBE: begin
        if (sts.ub_done) begin
          cmd.sh_init = 1'b1;
          state_nxt   = S_SHIFT;
        end else begin
          cmd.ub_probe = 1'b1;
          state_nxt    = S_UB_CMP;
        end
      end
      S_UB_CMP: begin
        cmd.ub_step = 1'b1;
        state_nxt   = S_UB_PROBE;
      end
      S_SHIFT: begin
        cmd.sh_step = 1'b1;
        if (sts.sh_fin) begin
          cmd.map_init = 1'b1;
          state_nxt    = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_step = 1'b1;
        if (sts.mp_fin) begin
          state_nxt = S_RESP_OK;
        end
      end
      S_KS_PROBE: begin
        cmd.ks_probe = 1'b1;
        state_nxt    = S_KS_CMP;
      end
      S_KS_CMP: begin
        if (sts.ks_eq) begin
          state_nxt = S_RESP_ENT;
        end else if (sts.ks_last) begin
          state_nxt = S_RESP_MISS;
        end else begin
          cmd.ks_step = 1'b1;
          state_nxt   = sts.ks_cont ? S_KS_PROBE : S_RESP_MISS;
        end
      end
      S_NL_MAP: begin
        cmd.nl_map_rd = 1'b1;
        state_nxt     = S_NL_ENT;
      end
      S_NL_ENT: begin
        cmd.nl_ent_rd = 1'b1;
        state_nxt     = S_RESP_ENT;
      end
      S_RESP_OK, S_RESP_MISS, S_RESP_FULL, S_RESP_ENT: begin
        case (state_r)
          S_RESP_MISS: cmd.res_status = STAT_MISS;
          S_RESP_FULL: cmd.res_status = STAT_FULL;
          default:     cmd.res_status = STAT_OK;
        endcase
        cmd.res_entry = (state_r == S_RESP_ENT);
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/skt_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_dpath
// entry and map memories, search and shift pointers, result register
// ---------------------------------------------------------------------------
`include "sorted_key_table_with_binary_search_assert.svh"

module skt_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  skt_pkg::cmd_t              cmd,
  output skt_pkg::sts_t              sts,
  input  logic [skt_pkg::OP_W-1:0]   in_operation,
  input  logic [skt_pkg::NUM_W-1:0]  in_item_number,
  input  logic [skt_pkg::KEY_W-1:0]  in_key,
  input  logic [skt_pkg::WGT_W-1:0]  in_weight_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [skt_pkg::STAT_W-1:0] out_status,
  output logic [skt_pkg::NUM_W-1:0]  out_found_number,
  output logic [skt_pkg::KEY_W-1:0]  out_found_key,
  output logic [skt_pkg::WGT_W-1:0]  out_found_weight
);
  import skt_pkg::*;

  entry_t           ent_mem [TABLE_DEPTH];
  logic [POS_W-1:0] map_mem [TABLE_DEPTH];

  op_t              req_op_r;
  logic [NUM_W-1:0] req_num_r;
  logic [KEY_W-1:0] req_key_r;
  logic [WGT_W-1:0] req_wgt_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] lo_r;
  logic [CNT_W-1:0] hi_r;
  logic [POS_W-1:0] mid_r;
  logic [CNT_W-1:0] sh_k_r;
  logic             sh_pend_r;
  logic [POS_W-1:0] sh_addr_r;
  logic [CNT_W-1:0] mp_k_r;
  logic             mp_pend_r;
  logic [POS_W-1:0] mp_pos_r;
  logic signed [SGN_W-1:0] top_r;
  logic signed [SGN_W-1:0] bot_r;
  logic [POS_W-1:0] probe_r;
  logic             par_r;
  logic [POS_W-1:0] map_rd_r;
  entry_t           ent_rd_r;

  logic             out_valid_r;
  status_t          out_status_r;
  entry_t           out_entry_r;

  logic [CNT_W:0]          ub_sum;
  logic [POS_W-1:0]        ub_mid;
  logic signed [SGN_W:0]   ks_sum;
  logic [POS_W-1:0]        ks_probe_w;
  logic                    ks_lt;
  logic signed [SGN_W-1:0] probe_s;
  logic signed [SGN_W-1:0] par_s;
  logic signed [SGN_W-1:0] ks_top_new;
  logic signed [SGN_W-1:0] ks_bot_new;
  logic                    sh_more;
  logic                    mp_more;
  logic                    ent_rd_en;
  logic [POS_W-1:0]        ent_rd_addr;
  logic                    ent_we;
  logic [POS_W-1:0]        ent_wa;
  entry_t                  ent_wd;
  logic                    map_we;
  logic [POS_W-1:0]        map_wa;

  assign ub_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign ub_mid     = POS_W'(ub_sum >> 1);
  assign ks_sum     = {top_r[SGN_W-1], top_r} + {bot_r[SGN_W-1], bot_r};
  assign ks_probe_w = ks_sum[POS_W:1];
  assign ks_lt      = ent_rd_r.key < req_key_r;
  assign probe_s    = $signed(SGN_W'(probe_r));
  assign par_s      = $signed(SGN_W'(par_r));
  // a probe below the key lifts bottom, otherwise top drops
  assign ks_bot_new = ks_lt ? probe_s + par_s : bot_r;
  assign ks_top_new = ks_lt ? top_r : probe_s - par_s;
  assign sh_more    = sh_k_r > lo_r;
  assign mp_more    = mp_k_r < count_r;

  always_comb begin
    sts.op         = req_op_r;
    sts.count_zero = (count_r == '0);
    sts.count_full = (count_r >= CNT_W'(TABLE_DEPTH));
    sts.num_bad    = (req_num_r == '0) || (NC_W'(req_num_r) > NC_W'(count_r));
    sts.ub_done    = (lo_r == hi_r);
    sts.sh_fin     = !sh_pend_r && !sh_more;
    sts.mp_fin     = !mp_pend_r && !mp_more;
    sts.ks_eq      = (ent_rd_r.key == req_key_r);
    sts.ks_last    = (top_r == bot_r);
    sts.ks_cont    = (ks_top_new >= ks_bot_new);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // entry memory port selection
  always_comb begin
    ent_rd_en   = 1'b0;
    ent_rd_addr = '0;
    ent_we      = 1'b0;
    ent_wa      = '0;
    ent_wd      = ent_rd_r;
    if (cmd.ub_probe) begin
      ent_rd_en   = 1'b1;
      ent_rd_addr = ub_mid;
    end
    if (cmd.sh_step) begin
      if (sh_more) begin
        ent_rd_en   = 1'b1;
        ent_rd_addr = POS_W'(sh_k_r - CNT_W'(1));
      end
      if (sh_pend_r) begin
        ent_we = 1'b1;
        ent_wa = sh_addr_r;
      end else if (!sh_more) begin
        ent_we        = 1'b1;
        ent_wa        = POS_W'(lo_r);
        ent_wd.number = req_num_r;
        ent_wd.key    = req_key_r;
        ent_wd.weight = req_wgt_r;
      end
    end
    if (cmd.map_step && mp_more) begin
      ent_rd_en   = 1'b1;
      ent_rd_addr = POS_W'(mp_k_r);
    end
    if (cmd.ks_probe) begin
      ent_rd_en   = 1'b1;
      ent_rd_addr = ks_probe_w;
    end
    if (cmd.nl_ent_rd) begin
      ent_rd_en   = 1'b1;
      ent_rd_addr = map_rd_r;
    end
  end

  // numbers outside 1..depth get no map slot
  always_comb begin
    map_we = cmd.map_step && mp_pend_r && (ent_rd_r.number != '0) &&
             (ent_rd_r.number <= NUM_W'(TABLE_DEPTH));
    map_wa = POS_W'(ent_rd_r.number - NUM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_rd_en) begin
      ent_rd_r <= ent_mem[ent_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= mp_pos_r;
    end
    if (cmd.nl_map_rd) begin
      map_rd_r <= map_mem[POS_W'(req_num_r - NUM_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sh_pend_r   <= 1'b0;
      mp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.sh_step && sts.sh_fin) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.sh_init) begin
        sh_pend_r <= 1'b0;
      end else if (cmd.sh_step) begin
        sh_pend_r <= sh_more;
      end
      if (cmd.map_init) begin
        mp_pend_r <= 1'b0;
      end else if (cmd.map_step) begin
        mp_pend_r <= mp_more;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op_r  <= op_t'(in_operation);
      req_num_r <= in_item_number;
      req_key_r <= in_key;
      req_wgt_r <= in_weight_word;
    end
    if (cmd.ub_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end
    if (cmd.ub_probe) begin
      mid_r <= ub_mid;
    end
    if (cmd.ub_step) begin
      if (ent_rd_r.key > req_key_r) begin
        hi_r <= CNT_W'(mid_r);
      end else begin
        lo_r <= CNT_W'(mid_r) + CNT_W'(1);
      end
    end
    if (cmd.sh_init) begin
      sh_k_r <= count_r;
    end else if (cmd.sh_step && sh_more) begin
      sh_k_r    <= sh_k_r - CNT_W'(1);
      sh_addr_r <= POS_W'(sh_k_r);
    end
    if (cmd.map_init) begin
      mp_k_r <= lo_r;
    end else if (cmd.map_step && mp_more) begin
      mp_k_r   <= mp_k_r + CNT_W'(1);
      mp_pos_r <= POS_W'(mp_k_r);
    end
    if (cmd.ks_init) begin
      top_r <= $signed(SGN_W'(count_r) - SGN_W'(1));
      bot_r <= '0;
    end else if (cmd.ks_step) begin
      top_r <= ks_top_new;
      bot_r <= ks_bot_new;
    end
    if (cmd.ks_probe) begin
      probe_r <= ks_probe_w;
      par_r   <= ks_sum[0];
    end
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_entry_r  <= cmd.res_entry ? ent_rd_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_number = out_entry_r.number;
  assign out_found_key    = out_entry_r.key;
  assign out_found_weight = out_entry_r.weight;

  `SKT_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_DEPTH),
    "entry count above table depth")
  `SKT_ASSERT_SAME(a_ub_window, cmd.ub_probe, lo_r < hi_r,
    "insert search probed an empty window")
  `SKT_ASSERT_NEXT(a_insert_grow, cmd.sh_step && sts.sh_fin,
    count_r == $past(count_r) + CNT_W'(1), "insert did not grow the table by one")
  `SKT_ASSERT_SAME(a_map_pos, map_we, CNT_W'(mp_pos_r) < count_r,
    "map slot written with a position beyond the table")
  `SKT_ASSERT_SAME(a_result_slot, cmd.res_load, !out_valid_r || out_ready,
    "result loaded over an untaken beat")

endmodule

// ===== hdl/sorted_key_table_with_binary_search.sv =====
`timescale 1ns / 1ps
// a key lookup makes at most 1 + ceil(log2(count)) probes; a lookup by number reads the
// map slot, then the entry; an insert makes at most ceil(log2(count+1)) search probes,
// shifts the entries at and above the insert position up by one, writes the new entry and
// renews the map slots from the insert position up; one item at a time, next beat taken
// the cycle after the result is loaded
// reset clears the entry count and the handshake state; memories are not swept
// ---------------------------------------------------------------------------
// sorted_key_table_with_binary_search
// sorted key table with insert, clear and binary search lookups
// ---------------------------------------------------------------------------
module sorted_key_table_with_binary_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [skt_pkg::OP_W-1:0]   in_operation,
  input  logic [skt_pkg::NUM_W-1:0]  in_item_number,
  input  logic [skt_pkg::KEY_W-1:0]  in_key,
  input  logic [skt_pkg::WGT_W-1:0]  in_weight_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [skt_pkg::STAT_W-1:0] out_status,
  output logic [skt_pkg::NUM_W-1:0]  out_found_number,
  output logic [skt_pkg::KEY_W-1:0]  out_found_key,
  output logic [skt_pkg::WGT_W-1:0]  out_found_weight
);
  import skt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skt_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_item_number   (in_item_number),
    .in_key           (in_key),
    .in_weight_word   (in_weight_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_number (out_found_number),
    .out_found_key    (out_found_key),
    .out_found_weight (out_found_weight)
  );

endmodule
